### src/dars_pkg.sv
`default_nettype none
package dars_pkg;

  localparam int TAG_W     = 16;
  localparam int COORD_W   = 32;
  localparam int DIST_W    = 32;
  localparam int TMAG_W    = 48;
  localparam int CFG_IDX_W = 3;

  // Long divider: dividend and divisor widths, one quotient bit per stage.
  localparam int DIV_NUM_W  = 80;
  localparam int DIV_DEN_W  = 64;
  localparam int DIV_STAGES = DIV_NUM_W;

  // Square root: one result bit per stage.
  localparam int SQRT_STAGES = DIST_W;

  // Start edge to result strobe.
  localparam int PIPE_LATENCY = SQRT_STAGES + 2 * DIV_STAGES + 10;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DISTANCE   = 3'd0,
    CFG_MAX_DISTANCE   = 3'd1,
    CFG_QUADRATIC_GAIN = 3'd2,
    CFG_LINEAR_GAIN    = 3'd3,
    CFG_CONSTANT_GAIN  = 3'd4
  } cfg_idx_e;

  // Per-item payload that travels down the pipeline.
  typedef struct packed {
    logic [TAG_W-1:0]            tag;
    logic [2:0][COORD_W-1:0]     pos;
    logic [2:0][COORD_W-1:0]     dmag;
    logic [2:0]                  dneg;
    logic [31:0]                 elapsed;
    logic [DIST_W-1:0]           dd;
    logic                        moved;
    logic [31:0]                 speed;
    logic [TMAG_W-1:0]           tmag;
    logic                        tneg;
  } item_t;

endpackage
`default_nettype wire

### src/dars_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module dars_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [dars_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [dars_pkg::DIV_DEN_W-1:0] den_i,
  output logic                          valid_o,
  output logic [dars_pkg::DIV_NUM_W-1:0] quot_o
);
  import dars_pkg::*;

  typedef struct packed {
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_t;

  // One step: shift in the next dividend bit, subtract when it fits.
  // The quotient bit replaces the dividend bit that was consumed.
  function automatic div_t div_step(div_t s);
    div_t             r;
    logic [DIV_DEN_W:0] t;
    logic             ge;
    t     = {s.rem, s.num[DIV_NUM_W-1]};
    ge    = t >= {1'b0, s.den};
    r.den = s.den;
    r.rem = ge ? DIV_DEN_W'(t - {1'b0, s.den}) : t[DIV_DEN_W-1:0];
    r.num = {s.num[DIV_NUM_W-2:0], ge};
    return r;
  endfunction

  div_t                  st_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_q;
  div_t                  init;

  assign init = '{rem: '0, num: num_i, den: den_i};

  // Stage registers.
  always_ff @(posedge clk_i) begin
    st_q[0] <= div_step(init);
    for (int i = 1; i < DIV_STAGES; i++) begin
      st_q[i] <= div_step(st_q[i-1]);
    end
  end

  // Valid bits run alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign quot_o  = st_q[DIV_STAGES-1].num;

endmodule
`default_nettype wire

### src/distance_attract_repel_step_core.sv
`default_nettype none
// Attract/repel step for one particle per item, fully pipelined. A new item is
// taken in every clock cycle (busy_o stays low) and its result appears on the
// result ports, marked by done_o for one cycle, after passing through 32
// square-root stages for the distance, 80 divider stages for the 1/d^2 and 1/d
// terms, 80 divider stages for the per-axis move, and ten arithmetic and I/O
// register stages. The receiver cannot stall, so results come out in input
// order at the input rate. Configuration writes are always accepted and must
// only be made while no item is in flight.
module distance_attract_repel_step_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [dars_pkg::TAG_W-1:0] particle_tag_i,
  input  logic signed [31:0]         pos_x_i,
  input  logic signed [31:0]         pos_y_i,
  input  logic signed [31:0]         pos_z_i,
  input  logic signed [31:0]         disp_x_i,
  input  logic signed [31:0]         disp_y_i,
  input  logic signed [31:0]         disp_z_i,
  input  logic [31:0]                elapsed_i,
  output logic                       done_o,
  output logic [dars_pkg::TAG_W-1:0] tag_out_o,
  output logic signed [31:0]         new_x_o,
  output logic signed [31:0]         new_y_o,
  output logic signed [31:0]         new_z_o,
  output logic                       moved_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [dars_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                cfg_data_i
);
  import dars_pkg::*;

  localparam logic [63:0] QM_CLAMP = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] n;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // One digit of the bitwise square root.
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t       r;
    logic [35:0] r2;
    logic [35:0] trial;
    logic        ge;
    r2     = {s.rem, s.n[63:62]};
    trial  = {2'b00, s.root, 2'b01};
    ge     = r2 >= trial;
    r.rem  = ge ? 34'(r2 - trial) : r2[33:0];
    r.root = {s.root[30:0], ge};
    r.n    = {s.n[61:0], 2'b00};
    return r;
  endfunction

  function automatic logic [31:0] sat32(logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -37'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [31:0] min_q, max_q, quad_q, lin_q, cnst_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= '1;
      quad_q <= '0;
      lin_q  <= '0;
      cnst_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_DISTANCE:   min_q  <= cfg_data_i;
        CFG_MAX_DISTANCE:   max_q  <= cfg_data_i;
        CFG_QUADRATIC_GAIN: quad_q <= cfg_data_i;
        CFG_LINEAR_GAIN:    lin_q  <= cfg_data_i;
        CFG_CONSTANT_GAIN:  cnst_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of the plain register stages.
  logic in_vld_q, p1_vld_q, p2_vld_q, p3_vld_q;
  logic p4_vld_q, p5_vld_q, p6_vld_q, p7_vld_q, p8_vld_q;
  logic [SQRT_STAGES-1:0] sq_vld_q;
  logic d1q_vld, d1l_vld;
  logic [2:0] d2_vld;

  item_t in_item_q, p1_item_q, p2_item_q, p3_item_q;
  item_t p4_item_q, p5_item_q, p6_item_q, p7_item_q, p8_item_q;
  item_t sq_item_q [SQRT_STAGES];
  item_t d1_item_q [DIV_STAGES];
  item_t d2_item_q [DIV_STAGES];
  sqrt_t sq_q [SQRT_STAGES];
  sqrt_t sq_init;

  logic [2:0][63:0]          p1_sq_q;
  logic [63:0]               p2_sum_q;
  logic [DIV_NUM_W-1:0]      p3_qnum_q, p3_lnum_q;
  logic [DIV_DEN_W-1:0]      p3_qden_q, p3_lden_q;
  logic [DIV_NUM_W-1:0]      q_quot, l_quot;
  logic [63:0]               p5_prod_q;
  logic [2:0][63:0]          p7_pl_q;
  logic [2:0][47:0]          p7_ph_q;
  logic [2:0][DIV_NUM_W-1:0] p8_num_q;
  logic [2:0][DIV_NUM_W-1:0] m_quot;

  logic                      done_q, moved_q;
  logic [TAG_W-1:0]          tag_q;
  logic [2:0][31:0]          new_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      sq_vld_q <= '0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
      p6_vld_q <= 1'b0;
      p7_vld_q <= 1'b0;
      p8_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start_i;
      p1_vld_q <= in_vld_q;
      p2_vld_q <= p1_vld_q;
      sq_vld_q <= {sq_vld_q[SQRT_STAGES-2:0], p2_vld_q};
      p3_vld_q <= sq_vld_q[SQRT_STAGES-1];
      p4_vld_q <= d1q_vld & d1l_vld;
      p5_vld_q <= p4_vld_q;
      p6_vld_q <= p5_vld_q;
      p7_vld_q <= p6_vld_q;
      p8_vld_q <= p7_vld_q;
      done_q   <= &d2_vld;
    end
  end

  // Input stage: capture the item and take displacement magnitudes.
  logic [2:0][31:0] disp_in;
  item_t            in_item_d;
  assign disp_in = {disp_z_i, disp_y_i, disp_x_i};

  always_comb begin
    in_item_d         = '0;
    in_item_d.tag     = particle_tag_i;
    in_item_d.pos     = {pos_z_i, pos_y_i, pos_x_i};
    in_item_d.elapsed = elapsed_i;
    for (int a = 0; a < 3; a++) begin
      in_item_d.dneg[a] = disp_in[a][31];
      in_item_d.dmag[a] = disp_in[a][31] ? 32'(-disp_in[a]) : disp_in[a];
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q <= in_item_d;
  end

  // Squares, then their sum.
  always_ff @(posedge clk_i) begin
    p1_item_q <= in_item_q;
    for (int a = 0; a < 3; a++) begin
      p1_sq_q[a] <= in_item_q.dmag[a] * in_item_q.dmag[a];
    end
    p2_item_q <= p1_item_q;
    p2_sum_q  <= p1_sq_q[0] + p1_sq_q[1] + p1_sq_q[2];
  end

  // Square root pipeline with the item riding alongside.
  assign sq_init = '{n: p2_sum_q, rem: '0, root: '0};

  always_ff @(posedge clk_i) begin
    sq_q[0]      <= sqrt_step(sq_init);
    sq_item_q[0] <= p2_item_q;
    for (int i = 1; i < SQRT_STAGES; i++) begin
      sq_q[i]      <= sqrt_step(sq_q[i-1]);
      sq_item_q[i] <= sq_item_q[i-1];
    end
  end

  // Bounds test and divider operands.
  logic [31:0] dist_root;
  logic [31:0] qabs, labs;
  item_t       p3_item_d;
  assign dist_root = sq_q[SQRT_STAGES-1].root;
  assign qabs = quad_q[31] ? 32'(-quad_q) : quad_q;
  assign labs = lin_q[31] ? 32'(-lin_q) : lin_q;

  always_comb begin
    p3_item_d       = sq_item_q[SQRT_STAGES-1];
    p3_item_d.dd    = dist_root;
    p3_item_d.moved = (dist_root > min_q) && (dist_root < max_q);
  end

  always_ff @(posedge clk_i) begin
    p3_item_q <= p3_item_d;
    p3_qnum_q <= {16'b0, qabs, 32'b0};
    p3_qden_q <= dist_root * dist_root;
    p3_lnum_q <= {32'b0, labs, 16'b0};
    p3_lden_q <= {32'b0, dist_root};
  end

  dars_div u_div_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p3_vld_q),
    .num_i   (p3_qnum_q),
    .den_i   (p3_qden_q),
    .valid_o (d1q_vld),
    .quot_o  (q_quot)
  );

  dars_div u_div_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p3_vld_q),
    .num_i   (p3_lnum_q),
    .den_i   (p3_lden_q),
    .valid_o (d1l_vld),
    .quot_o  (l_quot)
  );

  always_ff @(posedge clk_i) begin
    d1_item_q[0] <= p3_item_q;
    for (int i = 1; i < DIV_STAGES; i++) begin
      d1_item_q[i] <= d1_item_q[i-1];
    end
  end

  // Speed: signed sum of the three terms, saturated to Q16.16.
  logic [63:0]        qm;
  logic [47:0]        lm;
  logic signed [65:0] qterm, lterm, cterm, speed_w;
  logic [31:0]        speed_sat;
  item_t              p4_item_d;

  always_comb begin
    qm      = (q_quot > DIV_NUM_W'(QM_CLAMP)) ? QM_CLAMP : q_quot[63:0];
    lm      = l_quot[47:0];
    qterm   = quad_q[31] ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
    lterm   = lin_q[31] ? -$signed({18'b0, lm}) : $signed({18'b0, lm});
    cterm   = $signed({{34{cnst_q[31]}}, cnst_q});
    speed_w = qterm + lterm + cterm;
    if (speed_w > 66'sh7FFF_FFFF) begin
      speed_sat = 32'h7FFF_FFFF;
    end else if (speed_w < -66'sh8000_0000) begin
      speed_sat = 32'h8000_0000;
    end else begin
      speed_sat = speed_w[31:0];
    end
    p4_item_d       = d1_item_q[DIV_STAGES-1];
    p4_item_d.speed = speed_sat;
  end

  // Step length: |speed| * elapsed, clipped above to the distance when the speed is not negative.
  logic [31:0]       smag;
  logic [TMAG_W-1:0] tm_raw, tm_clip;
  logic              sneg6;
  item_t             p6_item_d;

  assign smag    = p4_item_q.speed[31] ? 32'(-p4_item_q.speed) : p4_item_q.speed;
  assign tm_raw  = p5_prod_q[63:16];
  assign sneg6   = p5_item_q.speed[31];
  assign tm_clip = (!sneg6 && tm_raw > {16'b0, p5_item_q.dd}) ? {16'b0, p5_item_q.dd}
                                                                : tm_raw;

  always_comb begin
    p6_item_d      = p5_item_q;
    p6_item_d.tmag = tm_clip;
    p6_item_d.tneg = sneg6 && (tm_raw != '0);
  end

  always_ff @(posedge clk_i) begin
    p4_item_q <= p4_item_d;
    p5_item_q <= p4_item_q;
    p5_prod_q <= smag * p4_item_q.elapsed;
    p6_item_q <= p6_item_d;
    // Move numerator |disp| * t, split into two partial products.
    p7_item_q <= p6_item_q;
    p8_item_q <= p7_item_q;
    for (int a = 0; a < 3; a++) begin
      p7_pl_q[a]  <= p6_item_q.dmag[a] * p6_item_q.tmag[31:0];
      p7_ph_q[a]  <= p6_item_q.dmag[a] * p6_item_q.tmag[47:32];
      p8_num_q[a] <= {16'b0, p7_pl_q[a]} + {p7_ph_q[a], 32'b0};
    end
  end

  // Per-axis division by the distance.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    dars_div u_div_m (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (p8_vld_q),
      .num_i   (p8_num_q[a]),
      .den_i   ({32'b0, p8_item_q.dd}),
      .valid_o (d2_vld[a]),
      .quot_o  (m_quot[a])
    );
  end

  always_ff @(posedge clk_i) begin
    d2_item_q[0] <= p8_item_q;
    for (int i = 1; i < DIV_STAGES; i++) begin
      d2_item_q[i] <= d2_item_q[i-1];
    end
  end

  // Apply the move and saturate each coordinate.
  item_t             fin;
  logic [2:0][36:0]  np;

  assign fin = d2_item_q[DIV_STAGES-1];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [34:0]        mv;
      logic signed [36:0] pe;
      mv = (|m_quot[a][DIV_NUM_W-1:34]) ? {1'b1, 34'b0} : m_quot[a][34:0];
      pe = $signed({{5{fin.pos[a][31]}}, fin.pos[a]});
      np[a] = (fin.dneg[a] ^ fin.tneg) ? 37'(pe - $signed({2'b00, mv}))
                                       : 37'(pe + $signed({2'b00, mv}));
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= fin.tag;
    moved_q <= fin.moved;
    for (int a = 0; a < 3; a++) begin
      new_q[a] <= fin.moved ? sat32($signed(np[a])) : fin.pos[a];
    end
  end

  assign done_o    = done_q;
  assign tag_out_o = tag_q;
  assign new_x_o   = new_q[0];
  assign new_y_o   = new_q[1];
  assign new_z_o   = new_q[2];
  assign moved_o   = moved_q;

  // Every result traces back to an item started a fixed latency earlier.
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, PIPE_LATENCY))
    else $error("result without a matching item");

  a_tag_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> tag_out_o == $past(particle_tag_i, PIPE_LATENCY))
    else $error("tag does not match its item");

  a_unmoved_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !moved_o |-> new_x_o == $past(pos_x_i, PIPE_LATENCY))
    else $error("unmoved position changed");

endmodule
`default_nettype wire
